// ===== sv/bgk_pkg.sv =====
// bgk_pkg: shared types, op codes and the popcount helper for the grouped
// bitmap claim block
// no dependencies
package bgk_pkg;

    localparam int MAX_ENTRIES   = 64;
    localparam int OP_W          = 3;
    localparam int GROUP_W       = 2;
    localparam int SLOT_W        = 6;
    localparam int RANK_W        = 8;
    localparam int SIZE_W        = 7;
    localparam int FIG_W         = 7;
    localparam int TOTAL_W       = 9;
    localparam int CFG_IDX_W     = 2;
    localparam int NUM_SIZE_REGS = 4;
    localparam int CNT_W         = 7;

    localparam logic [OP_W-1:0] OP_LOAD      = 3'd0;
    localparam logic [OP_W-1:0] OP_SET       = 3'd1;
    localparam logic [OP_W-1:0] OP_CLAIM     = 3'd2;
    localparam logic [OP_W-1:0] OP_CLAIM_ALL = 3'd3;
    localparam logic [OP_W-1:0] OP_FREE_ALL  = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [GROUP_W-1:0] group;
        logic [SLOT_W-1:0]  slot;
        logic               claimed_value;
        logic               pinned_value;
        logic [RANK_W-1:0]  rank;
    } t_in;

    typedef struct packed {
        logic               changed;
        logic               found;
        logic [GROUP_W-1:0] out_group;
        logic [SLOT_W-1:0]  out_slot;
        logic               now_claimed;
        logic [FIG_W-1:0]   free_in_group;
        logic [TOTAL_W-1:0] free_total;
    } t_out;

    // byte counts first, then the sum of the eight byte counts
    function automatic logic [CNT_W-1:0] popcount64(input logic [MAX_ENTRIES-1:0] v);
        logic [3:0]       bcnt [8];
        logic [CNT_W-1:0] sum;
        for (int b = 0; b < 8; b++) begin
            bcnt[b] = 4'd0;
            for (int i = 0; i < 8; i++) begin
                bcnt[b] = bcnt[b] + 4'(v[8*b+i]);
            end
        end
        sum = '0;
        for (int b = 0; b < 8; b++) begin
            sum = sum + CNT_W'(bcnt[b]);
        end
        return sum;
    endfunction

endpackage

// ===== sv/bgk_mem.sv =====
// bgk_mem: one-port-write, one-port-read group word memory, registered read
// row valid flops make never-written rows read as zero; does not use bgk_pkg
module bgk_mem #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 192,
    parameter int AW    = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [WIDTH-1:0] r_rd_data;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                // forward a write to the same row in the same cycle
                if (i_wr_en && i_wr_addr == i_rd_addr) begin
                    r_rd_vld <= 1'b1;
                end else begin
                    r_rd_vld <= r_vld[i_rd_addr];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && i_wr_addr == i_rd_addr) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ===== sv/bgk_kth.sv =====
// bgk_kth: finds the position of the k-th set bit of a 64-bit word
// binary descent, one halving per cycle; uses bgk_pkg popcount64
module bgk_kth (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [bgk_pkg::MAX_ENTRIES-1:0]   i_word,
    input  logic [bgk_pkg::CNT_W-1:0]         i_rank,
    output logic                              o_done,
    output logic [bgk_pkg::SLOT_W-1:0]        o_pos
);
    import bgk_pkg::*;

    localparam logic [2:0] LAST_LVL = 3'(SLOT_W - 1);

    logic [MAX_ENTRIES-1:0] r_word;
    logic [CNT_W-1:0]       r_rank;
    logic [SLOT_W-1:0]      r_pos;
    logic [2:0]             r_lvl;
    logic                   r_busy;
    logic                   r_done;

    logic [SLOT_W:0]        win;
    logic [MAX_ENTRIES-1:0] lo_mask;
    logic [CNT_W-1:0]       lo_cnt;
    logic                   go_low;

    always_comb begin
        win     = 7'd32 >> r_lvl;
        lo_mask = (64'd1 << win) - 64'd1;
        lo_cnt  = popcount64(r_word & lo_mask);
        go_low  = r_rank < lo_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            // one-cycle pulse after the last halving
            r_done <= !i_start && r_busy && (r_lvl == LAST_LVL);
            if (i_start) begin
                r_busy <= 1'b1;
                r_word <= i_word;
                r_rank <= i_rank;
                r_pos  <= '0;
                r_lvl  <= '0;
            end else if (r_busy) begin
                if (!go_low) begin
                    r_rank <= r_rank - lo_cnt;
                    r_word <= r_word >> win;
                    r_pos  <= r_pos + SLOT_W'(win);
                end
                r_lvl <= r_lvl + 3'd1;
                if (r_lvl == LAST_LVL) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_pos  = r_pos;

endmodule

// ===== sv/grouped_bitmap_kth_free_claim_top.sv =====
// grouped_bitmap_kth_free_claim_top: grouped claimed/pinned/loaded bitmap with
// per-group free counts and rank claim; uses bgk_pkg, bgk_mem, bgk_kth
//
//   channel   signals                              direction
//   in        i_in_valid  o_in_ready   i_in_data   item in   (bgk_pkg::t_in)
//   out       o_out_valid i_out_ready  o_out_data  item out  (bgk_pkg::t_out)
//   cfg       i_cfg_valid o_cfg_ready  i_cfg_index i_cfg_data  size register write
//
// load and set step through accept, word read, then modify and write back
// unused ops and a claim whose rank is not below the free total go straight to the result
// claim walks the groups, one group count per cycle, then a
// six-step descent over the free bits of the chosen group word
// claim-all and free-all rewrite the memory one row per cycle
// a size write recounts its group; reset is synchronous and leaves every row
// reading as zero; a stalled output holds only the last step
module grouped_bitmap_kth_free_claim_top #(
    parameter int GROUPS            = 4,
    parameter int ENTRIES_PER_GROUP = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  bgk_pkg::t_in                   i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output bgk_pkg::t_out                  o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bgk_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bgk_pkg::SIZE_W-1:0]     i_cfg_data
);
    import bgk_pkg::*;

    localparam int EPG  = ENTRIES_PER_GROUP;
    localparam int GW   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int CW   = $clog2(EPG + 1);
    localparam int TW   = $clog2(GROUPS * EPG + 1);
    localparam int CMPW = (TW > RANK_W) ? TW : RANK_W;
    localparam int MW   = 3 * EPG;
    localparam logic [GW-1:0]     LAST_G   = GW'(GROUPS - 1);
    localparam logic [SIZE_W-1:0] EPG_SIZE = SIZE_W'(EPG);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SINGLE   = 3'd1;
    localparam logic [2:0] S_WALK     = 3'd2;
    localparam logic [2:0] S_KTH      = 3'd3;
    localparam logic [2:0] S_KTH_WAIT = 3'd4;
    localparam logic [2:0] S_BULK     = 3'd5;
    localparam logic [2:0] S_RECNT    = 3'd6;
    localparam logic [2:0] S_DONE     = 3'd7;

    logic [2:0]        r_state, n_state;
    t_in               r_in;
    logic [GW-1:0]     r_g;
    logic              r_gok;
    logic [RANK_W-1:0] r_r;
    logic [TW-1:0]     r_acc;
    logic [TW-1:0]     r_total;
    logic [CW-1:0]     r_gfc [GROUPS];
    logic [SIZE_W-1:0] r_size [NUM_SIZE_REGS];
    t_out              r_res;
    t_out              r_out;
    logic              r_out_valid;
    logic [EPG-1:0]    r_hold_claimed;
    logic [EPG-1:0]    r_hold_pinned;
    logic [EPG-1:0]    r_hold_loaded;

    logic              in_acc, cfg_acc;
    logic              mem_rd_en, mem_wr_en;
    logic [GW-1:0]     mem_rd_addr, mem_wr_addr;
    logic [MW-1:0]     mem_wr_data, mem_rd_data;
    logic [EPG-1:0]    rd_claimed, rd_pinned, rd_loaded;

    logic [SIZE_W-1:0]      g_size;
    logic [MAX_ENTRIES-1:0] g_mask64;
    logic [EPG-1:0]         g_mask, act;
    logic [CW-1:0]          gfc_cur;

    logic           in_grp_ok, cfg_grp_ok, rank_ok;
    logic [EPG-1:0] sg_bit, sg_claimed, sg_pinned, sg_loaded;
    logic           sg_ok, sg_newc, sg_oldc;
    logic [EPG-1:0] bk_claimed;
    logic [EPG-1:0] pc_in;
    logic [CW-1:0]  cnt;
    logic           walk_hit;
    logic           kth_start, kth_done;
    logic [SLOT_W-1:0] kth_pos;
    logic [EPG-1:0] kth_bit;
    logic [TW-1:0]  acc_sum;
    logic [TW-1:0]  total_adj;
    t_out           res_start;

    assign in_acc      = i_in_valid && o_in_ready;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign rd_claimed = mem_rd_data[EPG-1:0];
    assign rd_pinned  = mem_rd_data[2*EPG-1:EPG];
    assign rd_loaded  = mem_rd_data[3*EPG-1:2*EPG];

    assign in_grp_ok  = 32'(i_in_data.group) < GROUPS;
    assign cfg_grp_ok = 32'(i_cfg_index) < GROUPS;
    assign rank_ok    = CMPW'(i_in_data.rank) < CMPW'(r_total);

    // result of a new item before its op fills anything in
    always_comb begin
        res_start            = '0;
        res_start.free_total = TOTAL_W'(r_total);
    end

    // effective size of the current group, clamped to the row width
    always_comb begin
        if (32'(r_g) < NUM_SIZE_REGS) begin
            g_size = r_size[CFG_IDX_W'(r_g)];
        end else begin
            g_size = EPG_SIZE;
        end
        if (g_size > EPG_SIZE) begin
            g_size = EPG_SIZE;
        end
        g_mask64 = (g_size >= SIZE_W'(MAX_ENTRIES)) ? '1 : ((64'd1 << g_size) - 64'd1);
        g_mask   = EPG'(g_mask64);
        act      = g_mask & rd_loaded;
        gfc_cur  = r_gfc[r_g];
    end

    // single-entry load / set
    always_comb begin
        sg_bit  = EPG'(64'd1 << r_in.slot);
        sg_oldc = |(rd_claimed & sg_bit);
        sg_ok   = r_gok && (SIZE_W'(r_in.slot) < g_size)
                  && (r_in.op == OP_LOAD || (rd_loaded & sg_bit) != '0);
        sg_newc = (r_in.op == OP_LOAD && r_in.pinned_value) ? 1'b1 : r_in.claimed_value;
        sg_loaded = rd_loaded;
        sg_pinned = rd_pinned;
        if (r_in.op == OP_LOAD) begin
            sg_loaded = rd_loaded | sg_bit;
            sg_pinned = r_in.pinned_value ? (rd_pinned | sg_bit) : (rd_pinned & ~sg_bit);
        end
        sg_claimed = sg_newc ? (rd_claimed | sg_bit) : (rd_claimed & ~sg_bit);
    end

    always_comb begin
        if (r_in.op == OP_CLAIM_ALL) begin
            bk_claimed = rd_claimed | act;
        end else begin
            bk_claimed = rd_claimed & ~(act & ~rd_pinned);
        end
    end

    // one shared free counter for the row being written back or recounted
    always_comb begin
        case (r_state)
            S_SINGLE: pc_in = g_mask & sg_loaded & ~sg_claimed;
            S_BULK:   pc_in = act & ~bk_claimed;
            default:  pc_in = act & ~rd_claimed;
        endcase
        cnt = CW'(popcount64(MAX_ENTRIES'(pc_in)));
    end

    assign walk_hit  = (r_r < RANK_W'(gfc_cur)) || (r_g == LAST_G);
    assign kth_start = (r_state == S_KTH);
    assign kth_bit   = EPG'(64'd1 << kth_pos);
    assign acc_sum   = r_acc + TW'(cnt);
    assign total_adj = r_total - TW'(gfc_cur) + TW'(cnt);

    // memory port control
    always_comb begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_g;
        mem_wr_data = {sg_loaded, sg_pinned, sg_claimed};
        case (r_state)
            S_IDLE: begin
                if (cfg_acc) begin
                    mem_rd_en   = cfg_grp_ok;
                    mem_rd_addr = GW'(i_cfg_index);
                end else if (in_acc) begin
                    if ((i_in_data.op == OP_LOAD || i_in_data.op == OP_SET) && in_grp_ok) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = GW'(i_in_data.group);
                    end else if (i_in_data.op == OP_CLAIM_ALL
                                 || i_in_data.op == OP_FREE_ALL) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = '0;
                    end
                end
            end
            S_SINGLE: begin
                mem_wr_en = sg_ok;
            end
            S_WALK: begin
                mem_rd_en   = walk_hit;
                mem_rd_addr = r_g;
            end
            S_KTH_WAIT: begin
                mem_wr_en   = kth_done;
                mem_wr_data = {r_hold_loaded, r_hold_pinned, r_hold_claimed | kth_bit};
            end
            S_BULK: begin
                mem_wr_en   = 1'b1;
                mem_wr_data = {rd_loaded, rd_pinned, bk_claimed};
                mem_rd_en   = (r_g != LAST_G);
                mem_rd_addr = r_g + GW'(1);
            end
            default: begin
                mem_rd_en = 1'b0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (cfg_acc) begin
                    n_state = cfg_grp_ok ? S_RECNT : S_IDLE;
                end else if (in_acc) begin
                    case (i_in_data.op)
                        OP_LOAD, OP_SET:           n_state = S_SINGLE;
                        OP_CLAIM:                  n_state = rank_ok ? S_WALK : S_DONE;
                        OP_CLAIM_ALL, OP_FREE_ALL: n_state = S_BULK;
                        default:                   n_state = S_DONE;
                    endcase
                end
            end
            S_SINGLE:   n_state = S_DONE;
            S_WALK:     n_state = walk_hit ? S_KTH : S_WALK;
            S_KTH:      n_state = S_KTH_WAIT;
            S_KTH_WAIT: n_state = kth_done ? S_DONE : S_KTH_WAIT;
            S_BULK:     n_state = (r_g == LAST_G) ? S_DONE : S_BULK;
            S_RECNT:    n_state = S_IDLE;
            S_DONE:     n_state = (!r_out_valid || i_out_ready) ? S_IDLE : S_DONE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_total     <= '0;
            for (int g = 0; g < GROUPS; g++) begin
                r_gfc[g] <= '0;
            end
            for (int s = 0; s < NUM_SIZE_REGS; s++) begin
                r_size[s] <= EPG_SIZE;
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (cfg_acc) begin
                        r_size[i_cfg_index] <= i_cfg_data;
                        r_g <= GW'(i_cfg_index);
                    end else if (in_acc) begin
                        r_in         <= i_in_data;
                        r_gok        <= in_grp_ok;
                        if (i_in_data.op == OP_CLAIM || i_in_data.op == OP_CLAIM_ALL
                            || i_in_data.op == OP_FREE_ALL) begin
                            r_g <= '0;
                        end else begin
                            r_g <= in_grp_ok ? GW'(i_in_data.group) : '0;
                        end
                        r_r          <= i_in_data.rank;
                        r_acc        <= '0;
                        r_res        <= res_start;
                    end
                end
                S_SINGLE: begin
                    r_res.out_group <= r_in.group;
                    r_res.out_slot  <= r_in.slot;
                    r_res.changed   <= sg_ok && (sg_newc != sg_oldc);
                    if (!r_gok) begin
                        r_res.now_claimed   <= 1'b0;
                        r_res.free_in_group <= '0;
                    end else if (sg_ok) begin
                        r_res.now_claimed   <= sg_newc;
                        r_res.free_in_group <= FIG_W'(cnt);
                        r_res.free_total    <= TOTAL_W'(total_adj);
                        r_gfc[r_g]          <= cnt;
                        r_total             <= total_adj;
                    end else begin
                        r_res.now_claimed   <= sg_oldc;
                        r_res.free_in_group <= FIG_W'(gfc_cur);
                    end
                end
                S_WALK: begin
                    if (!walk_hit) begin
                        r_r <= r_r - RANK_W'(gfc_cur);
                        r_g <= r_g + GW'(1);
                    end
                end
                S_KTH: begin
                    r_hold_claimed <= rd_claimed;
                    r_hold_pinned  <= rd_pinned;
                    r_hold_loaded  <= rd_loaded;
                end
                S_KTH_WAIT: begin
                    if (kth_done) begin
                        // exactly one free entry leaves the group
                        r_gfc[r_g]          <= gfc_cur - CW'(1);
                        r_total             <= r_total - TW'(1);
                        r_res.found         <= 1'b1;
                        r_res.changed       <= 1'b1;
                        r_res.now_claimed   <= 1'b1;
                        r_res.out_group     <= GROUP_W'(r_g);
                        r_res.out_slot      <= kth_pos;
                        r_res.free_in_group <= FIG_W'(gfc_cur - CW'(1));
                        r_res.free_total    <= TOTAL_W'(r_total - TW'(1));
                    end
                end
                S_BULK: begin
                    r_gfc[r_g] <= cnt;
                    r_acc      <= acc_sum;
                    if (r_g == LAST_G) begin
                        r_total          <= acc_sum;
                        r_res.free_total <= TOTAL_W'(acc_sum);
                    end else begin
                        r_g <= r_g + GW'(1);
                    end
                end
                S_RECNT: begin
                    r_gfc[r_g] <= cnt;
                    r_total    <= total_adj;
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out <= r_res;
                    end
                end
                default: begin
                    r_acc <= r_acc;
                end
            endcase
        end
    end

    bgk_mem #(
        .DEPTH (GROUPS),
        .WIDTH (MW),
        .AW    (GW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .o_rd_data (mem_rd_data)
    );

    bgk_kth u_kth (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (kth_start),
        .i_word  (MAX_ENTRIES'(act & ~rd_claimed)),
        .i_rank  (CNT_W'(r_r)),
        .o_done  (kth_done),
        .o_pos   (kth_pos)
    );

endmodule
